### rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// shared types, codes and constants of the h-bridge speed to pwm block
// ----------------------------------------------------------------------------
package hbs_pkg;

    // motor count, 1 to 4
    localparam int MOTORS = 2;

    localparam int FUNC_W   = 3;
    localparam int MOTOR_W  = 2;
    localparam int SPEED_W  = 16;
    localparam int CMP_W    = 16;
    localparam int PCT_W    = 7;
    localparam int MASK_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W    = 10;

    localparam logic signed [SPEED_W-1:0] CLAMP_POS = 16'sd1000;
    localparam logic signed [SPEED_W-1:0] CLAMP_NEG = -16'sd1000;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // period * pct, and the reciprocal multiply for / 100
    localparam int PROD1_W      = CMP_W + PCT_W;
    localparam int DIV100_SHIFT = 30;
    localparam int RECIP100_W   = 24;
    localparam logic [RECIP100_W-1:0] RECIP_100 =
        RECIP100_W'((64'd1 << DIV100_SHIFT) / 100);
    localparam int REM1_W = 8;

    // mag * span, and the reciprocal multiply for / 1000
    localparam int PROD2_W       = MAG_W + CMP_W;
    localparam int DIV1000_SHIFT = 36;
    localparam int RECIP1000_W   = 27;
    localparam logic [RECIP1000_W-1:0] RECIP_1000 =
        RECIP1000_W'((64'd1 << DIV1000_SHIFT) / 1000);
    localparam logic [PROD2_W-1:0] SPEED_FULL = PROD2_W'(1000);
    localparam int REM2_W = 11;

    localparam logic [CMP_W-1:0] PERIOD_RST = 16'd2559;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_SPEED  = 3'd0,
        FUNC_STOP_COAST = 3'd1,
        FUNC_STOP_BRAKE = 3'd2,
        FUNC_ESTOP      = 3'd3,
        FUNC_ENABLE     = 3'd4,
        FUNC_DISABLE    = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD     = 3'd0,
        REG_CONFIGURED = 3'd1,
        REG_INVERT     = 3'd2,
        REG_MIN_DUTY_0 = 3'd3,
        REG_MIN_DUTY_1 = 3'd4,
        REG_MIN_DUTY_2 = 3'd5,
        REG_MIN_DUTY_3 = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        EMIT_DRIVE = 2'd0,
        EMIT_COAST = 2'd1,
        EMIT_BRAKE = 2'd2
    } emit_kind_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       do_mul1;
        logic       do_div1;
        logic       do_cor1;
        logic       do_mul2;
        logic       do_div2;
        logic       do_cor2;
        logic       emit;
        emit_kind_t emit_kind;
        logic       emit_scan;
        logic       emit_last;
        logic       scan_clr;
        logic       scan_inc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  usable;
        logic  scan_usable;
        logic  scan_last;
        logic  scan_end;
        logic  out_free;
    } sts_t;

endpackage

### rtl/hbs_ctrl.sv
// ----------------------------------------------------------------------------
// hbs_ctrl
// sequencer: decodes each command word and steps the datapath
// ----------------------------------------------------------------------------
module hbs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hbs_pkg::sts_t  sts,
    output hbs_pkg::cmd_t  cmd
);
    import hbs_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DECODE = 10'b00_0000_0010,
        ST_MUL1   = 10'b00_0000_0100,
        ST_DIV1   = 10'b00_0000_1000,
        ST_COR1   = 10'b00_0001_0000,
        ST_MUL2   = 10'b00_0010_0000,
        ST_DIV2   = 10'b00_0100_0000,
        ST_COR2   = 10'b00_1000_0000,
        ST_EMIT   = 10'b01_0000_0000,
        ST_SCAN   = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       enabled_reg, enabled_next;
    logic       brake_reg, brake_next;
    emit_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enabled_reg <= 1'b0;
            brake_reg   <= 1'b0;
            kind_reg    <= EMIT_DRIVE;
        end
        else
        begin
            state_reg   <= state_next;
            enabled_reg <= enabled_next;
            brake_reg   <= brake_next;
            kind_reg    <= kind_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        enabled_next = enabled_reg;
        brake_next   = brake_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.emit_kind = EMIT_DRIVE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                case (sts.func)
                    FUNC_SET_SPEED:
                    begin
                        if (sts.usable && enabled_reg)
                        begin
                            kind_next  = EMIT_DRIVE;
                            state_next = ST_MUL1;
                        end
                    end
                    FUNC_STOP_COAST:
                    begin
                        if (sts.usable)
                        begin
                            kind_next  = EMIT_COAST;
                            state_next = ST_EMIT;
                        end
                    end
                    FUNC_STOP_BRAKE:
                    begin
                        if (sts.usable)
                        begin
                            kind_next  = EMIT_BRAKE;
                            state_next = ST_EMIT;
                        end
                    end
                    FUNC_ESTOP:
                    begin
                        enabled_next = 1'b0;
                        brake_next   = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    FUNC_ENABLE:
                    begin
                        enabled_next = 1'b1;
                    end
                    FUNC_DISABLE:
                    begin
                        enabled_next = 1'b0;
                        brake_next   = 1'b0;
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL1:
            begin
                cmd.do_mul1 = 1'b1;
                state_next  = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.do_div1 = 1'b1;
                state_next  = ST_COR1;
            end
            ST_COR1:
            begin
                cmd.do_cor1 = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.do_mul2 = 1'b1;
                state_next  = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.do_div2 = 1'b1;
                state_next  = ST_COR2;
            end
            ST_COR2:
            begin
                cmd.do_cor2 = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = kind_reg;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_usable)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = brake_reg ? EMIT_BRAKE : EMIT_COAST;
                        cmd.emit_scan = 1'b1;
                        cmd.emit_last = sts.scan_last;
                        if (sts.scan_last)
                            state_next = ST_IDLE;
                        else
                            cmd.scan_inc = 1'b1;
                    end
                end
                else if (sts.scan_end)
                    state_next = ST_IDLE;
                else
                    cmd.scan_inc = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // never overwrite a result word that has not been taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while result register busy");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");

    a_estop_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE && sts.func == FUNC_ESTOP) |=> !enabled_reg)
        else $error("emergency stop left motors enabled");

    a_scan_usable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmd.emit) |-> sts.scan_usable)
        else $error("broadcast emitted for unusable motor");
`endif

endmodule

### rtl/hbs_dpath.sv
// ----------------------------------------------------------------------------
// hbs_dpath
// config registers, duty arithmetic, broadcast counter and result register
// ----------------------------------------------------------------------------
module hbs_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [hbs_pkg::FUNC_W-1:0]       func,
    input  logic [hbs_pkg::MOTOR_W-1:0]      motor,
    input  logic signed [hbs_pkg::SPEED_W-1:0] speed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hbs_pkg::MOTOR_W-1:0]      motor_id,
    output logic [hbs_pkg::CMP_W-1:0]        in1_compare,
    output logic [hbs_pkg::CMP_W-1:0]        in2_compare,
    output logic                             last,
    input  hbs_pkg::cmd_t                    cmd,
    output hbs_pkg::sts_t                    sts
);
    import hbs_pkg::*;

    // configuration
    logic [CMP_W-1:0]  period_reg;
    logic [MASK_W-1:0] configured_reg;
    logic [MASK_W-1:0] invert_reg;
    logic [PCT_W-1:0]  min_duty_pct_reg [MASK_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RST;
            configured_reg <= '0;
            invert_reg     <= '0;
            for (int i = 0; i < MASK_W; i++)
                min_duty_pct_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PERIOD:     period_reg          <= cfg_data[CMP_W-1:0];
                REG_CONFIGURED: configured_reg      <= cfg_data[MASK_W-1:0];
                REG_INVERT:     invert_reg          <= cfg_data[MASK_W-1:0];
                REG_MIN_DUTY_0: min_duty_pct_reg[0] <= cfg_data[PCT_W-1:0];
                REG_MIN_DUTY_1: min_duty_pct_reg[1] <= cfg_data[PCT_W-1:0];
                REG_MIN_DUTY_2: min_duty_pct_reg[2] <= cfg_data[PCT_W-1:0];
                REG_MIN_DUTY_3: min_duty_pct_reg[3] <= cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // motors that exist and are configured
    logic [MASK_W-1:0] usable_mask;
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
            usable_mask[i] = configured_reg[i] && (i < MOTORS);
    end

    // latched command word and prepared operands
    func_t              func_reg;
    logic [MOTOR_W-1:0] motor_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               pos_reg;
    logic               neg_reg;
    logic [PCT_W-1:0]   pct_reg;

    logic signed [SPEED_W-1:0] clamped;
    logic signed [SPEED_W-1:0] directed;
    logic [SPEED_W-1:0]        abs_val;
    logic [PCT_W-1:0]          pct_raw;

    always_comb
    begin
        if (speed > CLAMP_POS)
            clamped = CLAMP_POS;
        else if (speed < CLAMP_NEG)
            clamped = CLAMP_NEG;
        else
            clamped = speed;
        directed = invert_reg[motor] ? -clamped : clamped;
        abs_val  = directed[SPEED_W-1] ? SPEED_W'(-directed) : SPEED_W'(directed);
        pct_raw  = min_duty_pct_reg[motor];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            motor_reg <= motor;
            mag_reg   <= abs_val[MAG_W-1:0];
            pos_reg   <= (directed > 0);
            neg_reg   <= directed[SPEED_W-1];
            pct_reg   <= (pct_raw > PCT_FULL) ? PCT_FULL : pct_raw;
        end
    end

    // duty = min_duty + mag * (period - min_duty) / 1000
    // min_duty = period * pct / 100, both divides by reciprocal multiply
    logic [PROD1_W-1:0]  prod1_reg;
    logic [CMP_W-1:0]    q1_reg;
    logic [CMP_W-1:0]    min_duty_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [CMP_W-1:0]    q2_reg;
    logic [CMP_W-1:0]    duty_reg;

    logic [PROD1_W+RECIP100_W-1:0]  div1_full;
    logic [PROD1_W-1:0]             back1;
    logic [REM1_W-1:0]              rem1;
    logic [CMP_W-1:0]               span;
    logic [PROD2_W+RECIP1000_W-1:0] div2_full;
    logic [PROD2_W-1:0]             back2;
    logic [REM2_W-1:0]              rem2;
    logic [CMP_W:0]                 duty_sum;

    always_comb
    begin
        div1_full = (PROD1_W+RECIP100_W)'(prod1_reg) *
                    (PROD1_W+RECIP100_W)'(RECIP_100);
        back1     = PROD1_W'(q1_reg) * PROD1_W'(PCT_FULL);
        rem1      = REM1_W'(prod1_reg - back1);
        span      = period_reg - min_duty_reg;
        div2_full = (PROD2_W+RECIP1000_W)'(prod2_reg) *
                    (PROD2_W+RECIP1000_W)'(RECIP_1000);
        back2     = PROD2_W'(q2_reg) * SPEED_FULL;
        rem2      = REM2_W'(prod2_reg - back2);
        duty_sum  = (CMP_W+1)'(min_duty_reg) + (CMP_W+1)'(q2_reg)
                  + (CMP_W+1)'(rem2 >= REM2_W'(SPEED_FULL));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_mul1)
            prod1_reg <= PROD1_W'(period_reg) * PROD1_W'(pct_reg);
        if (cmd.do_div1)
            q1_reg <= div1_full[DIV100_SHIFT +: CMP_W];
        if (cmd.do_cor1)
            min_duty_reg <= q1_reg + CMP_W'(rem1 >= REM1_W'(PCT_FULL));
        if (cmd.do_mul2)
            prod2_reg <= PROD2_W'(mag_reg) * PROD2_W'(span);
        if (cmd.do_div2)
            q2_reg <= div2_full[DIV1000_SHIFT +: CMP_W];
        if (cmd.do_cor2)
            duty_reg <= duty_sum[CMP_W-1:0];
    end

    // broadcast walk over the motors
    logic [MOTOR_W-1:0] scan_cnt_reg;
    logic [MASK_W-1:0]  above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_cnt_reg <= '0;
        else if (cmd.scan_clr)
            scan_cnt_reg <= '0;
        else if (cmd.scan_inc)
            scan_cnt_reg <= scan_cnt_reg + MOTOR_W'(1);
    end

    assign above = usable_mask >> scan_cnt_reg;

    // result register
    logic               out_valid_reg;
    logic [MOTOR_W-1:0] motor_id_reg;
    logic [CMP_W-1:0]   in1_reg, in1_next;
    logic [CMP_W-1:0]   in2_reg, in2_next;
    logic               last_reg;
    logic [CMP_W-1:0]   drive_low;

    assign drive_low = period_reg - duty_reg;

    always_comb
    begin
        in1_next = period_reg;
        in2_next = period_reg;
        case (cmd.emit_kind)
            EMIT_DRIVE:
            begin
                if (pos_reg)
                    in2_next = drive_low;
                else if (neg_reg)
                    in1_next = drive_low;
            end
            EMIT_COAST:
            begin
                in1_next = '0;
                in2_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            motor_id_reg <= cmd.emit_scan ? scan_cnt_reg : motor_reg;
            in1_reg      <= in1_next;
            in2_reg      <= in2_next;
            last_reg     <= cmd.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motor_id    = motor_id_reg;
    assign in1_compare = in1_reg;
    assign in2_compare = in2_reg;
    assign last        = last_reg;

    always_comb
    begin
        sts.func        = func_reg;
        sts.usable      = usable_mask[motor_reg];
        sts.scan_usable = usable_mask[scan_cnt_reg];
        sts.scan_last   = (above[MASK_W-1:1] == '0);
        sts.scan_end    = (scan_cnt_reg == MOTOR_W'(MOTORS - 1));
        sts.out_free    = !out_valid_reg || out_ready;
    end

endmodule

### rtl/h_bridge_speed_to_pwm.sv
// ----------------------------------------------------------------------------
// h_bridge_speed_to_pwm
// motor command words mapped to the IN1 / IN2 compare values of an h-bridge
// ----------------------------------------------------------------------------
// Takes one command word at a time and returns zero or more result words,
// each carrying a motor index and the two compare values for its pwm pair;
// last marks the final result word of a command. A set speed word passes
// through decode, six register-to-register steps (period * percent,
// reciprocal divide by 100 with its correction, magnitude * span, reciprocal
// divide by 1000 with its correction) and the result load. Single-motor
// stops go from decode to the result load, enable and ignored words end
// after decode, and emergency stop or disable walk the broadcast counter
// over the motors one per cycle, held while a result waits for the result
// register, stopping at the last configured one. A stalled result register
// holds the block, since a new result waits for the old one to be taken;
// the input side reopens as soon as the last result is loaded.
// Config registers are written through cfg_we / cfg_index / cfg_data and
// should only change while the block is idle.
// ----------------------------------------------------------------------------
module h_bridge_speed_to_pwm (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_data,
    // command word
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hbs_pkg::FUNC_W-1:0]         func,
    input  logic [hbs_pkg::MOTOR_W-1:0]        motor,
    input  logic signed [hbs_pkg::SPEED_W-1:0] speed,
    // result word
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hbs_pkg::MOTOR_W-1:0]        motor_id,
    output logic [hbs_pkg::CMP_W-1:0]          in1_compare,
    output logic [hbs_pkg::CMP_W-1:0]          in2_compare,
    output logic                               last
);
    import hbs_pkg::*;

    // sequencer commands and datapath status
    cmd_t cmd;
    sts_t sts;

    // state machine: decode, arithmetic steps, result load, broadcast walk
    hbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // config registers, duty arithmetic and the result register
    hbs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .motor       (motor),
        .speed       (speed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_id    (motor_id),
        .in1_compare (in1_compare),
        .in2_compare (in2_compare),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
